// File: src/c3rb_pkg.sv
// Package for the 3x3 replicate-border convolution core.
// Holds payload structs, register codes and fixed-point constants.
// Used by the stream interface users and the core; depends on nothing.
package c3rb_pkg;

  localparam int PIX_W        = 16;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = 32;
  localparam int ROWSUM_W     = 34;
  localparam int SUM_W        = 36;
  localparam int OUT_W        = 24;
  localparam int FRAC_SHIFT   = 12;
  localparam int ROUND_BIAS   = 2048;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MIN_DIM      = 2;

  localparam int RING_SLOTS   = 4;
  localparam int SLOT_W       = $clog2(RING_SLOTS);
  localparam int TAPS         = 3;

  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  typedef struct packed {
    logic                    func;
    logic signed [PIX_W-1:0] in_pixel;
  } c3rb_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_value;
    logic                    out_last;
  } c3rb_out_t;

endpackage

// File: src/c3rb_stream_if.sv
// Valid/ready stream interface with a typed payload.
// A transfer happens on a rising edge with valid and ready both high. No dependencies.
interface c3rb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/c3rb_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read data appears in the cycle after the address; reads return the old word on a same-cycle write.
module c3rb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/conv3x3_replicate_border_core.sv
// Streaming 3x3 convolution with replicated borders, four row RAMs in a ring.
// Throughput: one item per cycle, drains included; input stalls only while eight results
// are outstanding (accepted into the pipe but not yet transferred on out_chan).
// Path: a result released by the transfer of an input item passes the RAM read, multiply, row
// sums and round/saturate into an 8-entry output FIFO before it reaches out_chan.
// Reset: synchronous, active low; clears counters, credits and FIFO; the row RAMs are not
// cleared and need no clearing pass, since only entries written this stream are read.
module conv3x3_replicate_border_core
  import c3rb_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int CHANNELS  = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  c3rb_stream_if.sink           in_chan,
  c3rb_stream_if.source         out_chan
);

  localparam int ROW_LEN   = MAX_WIDTH * CHANNELS;
  localparam int AW        = $clog2(ROW_LEN);
  localparam int RI_W      = $clog2(ROW_LEN + 1);
  localparam int NP_W      = RI_W + 1;
  localparam int CW0       = $clog2(MAX_WIDTH + 1);
  localparam int WC_W      = (CW0 > WIDTH_REG_W) ? CW0 : WIDTH_REG_W;
  localparam int RST_W     = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_ITEMS = RST_W * CHANNELS;
  localparam int OUT_MAX   = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN   = -(2 ** (OUT_W - 1));

  typedef struct packed {
    logic                  last;
    logic                  col0;
    slot_t                 top;
    slot_t                 mid;
    slot_t                 bot;
    logic [RING_SLOTS-1:0] fwd_a;
    logic [RING_SLOTS-1:0] fwd_b;
  } s1_ctl_t;

  // configuration
  logic [RI_W-1:0]         row_items_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [CFG_DATA_W-1:0]   coef_r [TAPS];
  logic [WC_W-1:0]         w_req, w_clamp;
  logic [HEIGHT_REG_W-1:0] h_req, h_clamp;
  logic                    geo_write;

  // stream position
  logic [AW-1:0]           in_pos_r, in_pos_nxt;
  logic [HEIGHT_REG_W-1:0] in_row_r, in_row_nxt;
  slot_t                   in_slot_r, in_slot_nxt;
  logic                    ahead_r, ahead_nxt, ahead_in;
  logic [AW-1:0]           out_pos_r, out_pos_nxt;
  logic [HEIGHT_REG_W-1:0] out_row_r, out_row_nxt;
  slot_t                   out_slot_r, out_slot_nxt;

  logic                    in_fire, pix_fire, in_row_end, in_last_row;
  logic                    out_last_row, out_row_end, frame_last, right_in, avail, emit;
  logic [HEIGHT_REG_W-1:0] need_row;
  logic [NP_W-1:0]         np_ext;
  logic [AW-1:0]           npos;
  logic                    in_ready;

  // RAM ports
  logic [RING_SLOTS-1:0]   ram_we;
  logic [PIX_W-1:0]        rd_a [RING_SLOTS];
  logic [PIX_W-1:0]        rd_b [RING_SLOTS];

  // pipeline
  logic                    v1_r, v2_r, v3_r;
  s1_ctl_t                 s1_nxt, s1_r;
  logic [PIX_W-1:0]        wd1_r;
  logic                    last2_r, last3_r;
  logic [PIX_W-1:0]        fa [RING_SLOTS];
  logic [PIX_W-1:0]        fb [RING_SLOTS];
  logic signed [PIX_W-1:0] win [TAPS][TAPS];
  logic signed [PIX_W-1:0] line_r [CHANNELS][TAPS];
  logic signed [PROD_W-1:0]   prod_r [TAPS][TAPS];
  logic signed [ROWSUM_W-1:0] rsum_r [TAPS];
  logic signed [SUM_W-1:0]    total, q_full;
  c3rb_out_t               res;

  // output FIFO and credits
  c3rb_out_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]        fifo_cnt_r, outstanding_r;
  logic                    pop;

  // ---------------------------------------------------------------- config
  always_comb begin
    w_req   = WC_W'(cfg_wdata[WIDTH_REG_W-1:0]);
    w_clamp = w_req;
    if (w_req < WC_W'(MIN_DIM)) begin
      w_clamp = WC_W'(MIN_DIM);
    end else if (w_req > WC_W'(MAX_WIDTH)) begin
      w_clamp = WC_W'(MAX_WIDTH);
    end
    h_req   = cfg_wdata[HEIGHT_REG_W-1:0];
    h_clamp = (h_req < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM) : h_req;
    geo_write = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_items_r <= RI_W'(RST_ITEMS);
      height_r    <= HEIGHT_REG_W'(RESET_HEIGHT);
      for (int l = 0; l < TAPS; l++) begin
        coef_r[l] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  row_items_r  <= RI_W'(w_clamp) * RI_W'(CHANNELS);
        REG_FRAME_HEIGHT: height_r     <= h_clamp;
        REG_COEF_TOP:     coef_r[0]    <= cfg_wdata;
        REG_COEF_MID:     coef_r[1]    <= cfg_wdata;
        REG_COEF_BOT:     coef_r[2]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ stream bookkeeping
  assign in_ready      = outstanding_r < (FIFO_AW + 1)'(FIFO_DEPTH);
  assign in_chan.ready = in_ready;

  always_comb begin
    in_fire     = in_chan.valid && in_ready;
    pix_fire    = in_fire && (in_chan.data.func == FUNC_PIXEL);
    in_row_end  = (RI_W'(in_pos_r) + RI_W'(1)) == row_items_r;
    in_last_row = (in_row_r + HEIGHT_REG_W'(1)) == height_r;

    in_pos_nxt  = in_pos_r;
    in_row_nxt  = in_row_r;
    in_slot_nxt = in_slot_r;
    ahead_in    = ahead_r;
    if (pix_fire) begin
      if (in_row_end) begin
        in_pos_nxt  = '0;
        in_slot_nxt = in_slot_r + slot_t'(1);
        if (in_last_row) begin
          in_row_nxt = '0;
          ahead_in   = 1'b1;
        end else begin
          in_row_nxt = in_row_r + HEIGHT_REG_W'(1);
        end
      end else begin
        in_pos_nxt = in_pos_r + AW'(1);
      end
    end

    // next pending output needs the pixel one row down and one column right
    out_last_row = (out_row_r + HEIGHT_REG_W'(1)) == height_r;
    need_row     = out_last_row ? out_row_r : out_row_r + HEIGHT_REG_W'(1);
    np_ext       = NP_W'(out_pos_r) + NP_W'(CHANNELS);
    right_in     = np_ext < NP_W'(row_items_r);
    npos         = right_in ? np_ext[AW-1:0] : out_pos_r;
    avail        = ahead_in || (in_row_nxt > need_row) ||
                   ((in_row_nxt == need_row) && (in_pos_nxt > npos));
    emit         = in_fire && avail;
    out_row_end  = (RI_W'(out_pos_r) + RI_W'(1)) == row_items_r;
    frame_last   = out_row_end && out_last_row;

    out_pos_nxt  = out_pos_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    ahead_nxt    = ahead_in;
    if (emit) begin
      if (out_row_end) begin
        out_pos_nxt  = '0;
        out_slot_nxt = out_slot_r + slot_t'(1);
        out_row_nxt  = out_last_row ? '0 : out_row_r + HEIGHT_REG_W'(1);
        if (frame_last) begin
          ahead_nxt = 1'b0;
        end
      end else begin
        out_pos_nxt = out_pos_r + AW'(1);
      end
    end

    for (int i = 0; i < RING_SLOTS; i++) begin
      ram_we[i]       = pix_fire && (in_slot_r == slot_t'(i));
      s1_nxt.fwd_a[i] = ram_we[i] && (in_pos_r == out_pos_r);
      s1_nxt.fwd_b[i] = ram_we[i] && (in_pos_r == npos);
    end
    s1_nxt.last = frame_last;
    s1_nxt.col0 = out_pos_r < AW'(CHANNELS);
    s1_nxt.top  = (out_row_r == '0) ? out_slot_r : out_slot_r - slot_t'(1);
    s1_nxt.mid  = out_slot_r;
    s1_nxt.bot  = out_last_row ? out_slot_r : out_slot_r + slot_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geo_write) begin
      in_pos_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      ahead_r    <= 1'b0;
      out_pos_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
    end else begin
      in_pos_r   <= in_pos_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      ahead_r    <= ahead_nxt;
      out_pos_r  <= out_pos_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
    end
  end

  // ------------------------------------------------------------- row RAMs
  // port a reads the center column, port b the right neighbor (clamped)
  for (genvar g = 0; g < RING_SLOTS; g++) begin : g_row
    c3rb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (ROW_LEN)
    ) u_row_ram (
      .clk     (clk),
      .we      (ram_we[g]),
      .waddr   (in_pos_r),
      .wdata   (in_chan.data.in_pixel),
      .raddr_a (out_pos_r),
      .raddr_b (npos),
      .rdata_a (rd_a[g]),
      .rdata_b (rd_b[g])
    );
  end

  // ------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= emit;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: forward a same-cycle write, pick rows, build the window
  always_comb begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      fa[i] = s1_r.fwd_a[i] ? wd1_r : rd_a[i];
      fb[i] = s1_r.fwd_b[i] ? wd1_r : rd_b[i];
    end
    win[0][1] = fa[s1_r.top];
    win[1][1] = fa[s1_r.mid];
    win[2][1] = fa[s1_r.bot];
    win[0][2] = fb[s1_r.top];
    win[1][2] = fb[s1_r.mid];
    win[2][2] = fb[s1_r.bot];
    // left column is the center seen CHANNELS outputs ago, or the center itself at column 0
    for (int l = 0; l < TAPS; l++) begin
      win[l][0] = s1_r.col0 ? win[l][1] : line_r[CHANNELS-1][l];
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    wd1_r <= in_chan.data.in_pixel;
    if (v1_r) begin
      for (int l = 0; l < TAPS; l++) begin
        line_r[0][l] <= win[l][1];
      end
      for (int k = 1; k < CHANNELS; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
    for (int l = 0; l < TAPS; l++) begin
      for (int m = 0; m < TAPS; m++) begin
        prod_r[l][m] <= PROD_W'(win[l][m]) *
                        PROD_W'($signed(coef_r[l][COEF_W*m +: COEF_W]));
      end
    end
    last2_r <= s1_r.last;
    // stage 2: one sum per mask row
    for (int l = 0; l < TAPS; l++) begin
      rsum_r[l] <= ROWSUM_W'(prod_r[l][0]) + ROWSUM_W'(prod_r[l][1]) +
                   ROWSUM_W'(prod_r[l][2]);
    end
    last3_r <= last2_r;
  end

  // stage 3: total, round half up to a signed 24-bit integer (Q24.0), saturate
  always_comb begin
    total  = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]) +
             SUM_W'(ROUND_BIAS);
    q_full = total >>> FRAC_SHIFT;
    if (q_full > SUM_W'(OUT_MAX)) begin
      res.out_value = OUT_W'(OUT_MAX);
    end else if (q_full < SUM_W'(OUT_MIN)) begin
      res.out_value = OUT_W'(OUT_MIN);
    end else begin
      res.out_value = q_full[OUT_W-1:0];
    end
    res.out_last = last3_r;
  end

  // ---------------------------------------------------------- output FIFO
  // credits cover every output from acceptance until its transfer, so the FIFO cannot overflow
  assign pop            = out_chan.valid && out_chan.ready;
  assign out_chan.valid = fifo_cnt_r != '0;
  assign out_chan.data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (v3_r) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      fifo_cnt_r    <= '0;
      outstanding_r <= '0;
    end else begin
      if (v3_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r    <= fifo_cnt_r + (FIFO_AW + 1)'(v3_r) - (FIFO_AW + 1)'(pop);
      outstanding_r <= outstanding_r + (FIFO_AW + 1)'(emit) - (FIFO_AW + 1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_fifo_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= outstanding_r)
    else $error("output FIFO holds more entries than outstanding credits");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("credit count above FIFO depth");

  a_in_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    RI_W'(in_pos_r) < row_items_r)
    else $error("input column position past row end");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && frame_last && !geo_write) |=> (out_pos_r == '0 && out_row_r == '0 && !ahead_r))
    else $error("output position not cleared after last pixel of frame");
`endif

endmodule

// File: tb/conv3x3_replicate_border_core_tb.sv
// Self-checking testbench for conv3x3_replicate_border_core.
// Drives pixel and drain transfers with random gaps and predicts every filtered output.
// Depends on c3rb_pkg, c3rb_stream_if and the core.
module conv3x3_replicate_border_core_tb
  import c3rb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W         = 2048;
  localparam int CHANS         = 1;
  localparam int ROW_LEN       = MAX_W * CHANS;
  localparam int IDLE_PCT      = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int MAX_REPORTS   = 10;

  localparam logic [PIX_W-1:0] PIX_MIN           = 16'h8000;
  localparam logic [PIX_W-1:0] PIX_MAX           = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_MIN         = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_MAX         = 16'h7FFF;
  localparam logic [COEF_W-1:0] Q12_ONE          = 16'h1000;
  localparam logic [COEF_W-1:0] Q12_MINUS_TWO    = 16'hE000;
  localparam logic [COEF_W-1:0] Q12_QUARTER      = 16'h0400;
  localparam logic [COEF_W-1:0] Q12_MINUS_QUARTER = 16'hFC00;

  typedef struct {
    c3rb_in_t item;
    bit       hold;  // wait for all outstanding results before presenting
  } feed_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  c3rb_stream_if #(.payload_t(c3rb_in_t))  in_chan ();
  c3rb_stream_if #(.payload_t(c3rb_out_t)) out_chan ();

  conv3x3_replicate_border_core #(
    .MAX_WIDTH(MAX_W),
    .CHANNELS (CHANS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  feed_t       feed_q[$];
  c3rb_out_t   filtered_q[$];
  int unsigned items_pushed;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  bit          steady;

  // Predictor state: four row buffers in a ring plus input/output position counters.
  logic signed [PIX_W-1:0] ring_rows [RING_SLOTS][ROW_LEN];
  logic [WIDTH_REG_W-1:0]  geo_w;
  logic [HEIGHT_REG_W-1:0] geo_h;
  logic [CFG_DATA_W-1:0]   coef_row [TAPS];
  int unsigned             in_cnt;
  int unsigned             out_cnt;
  slot_t                   in_slot;
  slot_t                   out_slot;
  bit                      in_ahead;

  function automatic int unsigned eff_width();
    if (geo_w < MIN_DIM) return MIN_DIM;
    if (geo_w > MAX_W) return MAX_W;
    return geo_w;
  endfunction

  function automatic int unsigned eff_height();
    return (geo_h < MIN_DIM) ? MIN_DIM : geo_h;
  endfunction

  function automatic void restart_stream();
    in_cnt   = 0;
    out_cnt  = 0;
    in_slot  = '0;
    out_slot = '0;
    in_ahead = 1'b0;
  endfunction

  // Consumes one item; returns 1 with the next filtered pixel if it can be released.
  function automatic bit convolve_step(input c3rb_in_t it, output c3rb_out_t res);
    int unsigned w, h, row_items, total, pix, ch, r, col, nr, nc, need;
    int unsigned col_of [TAPS];
    slot_t       slot_of [TAPS];
    longint      acc, q;
    logic signed [COEF_W-1:0] k;
    logic signed [PIX_W-1:0]  p;
    bit          last;
    res       = '0;
    w         = eff_width();
    h         = eff_height();
    row_items = w * CHANS;
    total     = row_items * h;
    if (it.func == FUNC_PIXEL) begin
      ring_rows[in_slot][in_cnt % row_items] = it.in_pixel;
      in_cnt++;
      if (in_cnt % row_items == 0) in_slot = in_slot + 1'b1;
      if (in_cnt >= total) begin
        in_cnt   = 0;
        in_ahead = 1'b1;
      end
    end
    pix = out_cnt / CHANS;
    ch  = out_cnt % CHANS;
    r   = pix / w;
    col = pix % w;
    if (r >= h) return 1'b0;
    nr   = (r + 1 < h) ? r + 1 : h - 1;
    nc   = (col + 1 < w) ? col + 1 : w - 1;
    need = (nr * w + nc) * CHANS + ch;
    if (!in_ahead && in_cnt <= need) return 1'b0;

    // border replication: clamp row and column neighbors to the frame
    slot_of[0] = (r > 0) ? out_slot - 1'b1 : out_slot;
    slot_of[1] = out_slot;
    slot_of[2] = (r + 1 < h) ? out_slot + 1'b1 : out_slot;
    col_of[0]  = (col > 0) ? col - 1 : 0;
    col_of[1]  = col;
    col_of[2]  = (col + 1 < w) ? col + 1 : w - 1;

    acc = 0;
    for (int l = 0; l < TAPS; l++) begin
      for (int m = 0; m < TAPS; m++) begin
        k   = coef_row[l][COEF_W*m +: COEF_W];
        p   = ring_rows[slot_of[l]][(col_of[m] * CHANS + ch) % ROW_LEN];
        acc += longint'(p) * longint'(k);
      end
    end
    // round half up, then drop the Q4.12 fraction
    q = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;

    out_cnt++;
    last = (out_cnt == total);
    if (out_cnt % row_items == 0) out_slot = out_slot + 1'b1;
    if (last) begin
      out_cnt  = 0;
      in_ahead = 1'b0;
    end
    res.out_value = q[OUT_W-1:0];
    res.out_last  = last;
    return 1'b1;
  endfunction

  task automatic report_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Input driver: holds data until transfer, predicts each accepted item.
  always @(posedge clk) begin : feed_driver
    c3rb_out_t pred;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (convolve_step(in_chan.data, pred)) filtered_q.push_back(pred);
        items_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (feed_q.size() != 0 && (!feed_q[0].hold || filtered_q.size() == 0) &&
            (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_chan.valid <= 1'b1;
          in_chan.data  <= feed_q[0].item;
          void'(feed_q.pop_front());
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    c3rb_out_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          report_error($sformatf("unexpected result value=%0d last=%0b",
                                 $signed(out_chan.data.out_value), out_chan.data.out_last));
        end else begin
          want = filtered_q.pop_front();
          if (out_chan.data.out_value !== want.out_value)
            report_error($sformatf("result %0d out_value exp=%0d got=%0d", results_seen,
                                   $signed(want.out_value), $signed(out_chan.data.out_value)));
          if (out_chan.data.out_last !== want.out_last)
            report_error($sformatf("result %0d out_last exp=%0b got=%0b", results_seen,
                                   want.out_last, out_chan.data.out_last));
        end
      end
      out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(func_t f, logic [PIX_W-1:0] v, bit hold);
    feed_t e;
    e.item.func     = f;
    e.item.in_pixel = v;
    e.hold          = hold;
    feed_q.push_back(e);
    items_pushed++;
  endtask

  // Wait until every item is taken and every prediction matched, then let the pipe empty.
  task automatic await_idle();
    do @(posedge clk); while (items_taken != items_pushed || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_FRAME_WIDTH: begin
        geo_w = val[WIDTH_REG_W-1:0];
        restart_stream();
      end
      REG_FRAME_HEIGHT: begin
        geo_h = val[HEIGHT_REG_W-1:0];
        restart_stream();
      end
      REG_COEF_TOP: coef_row[0] = val;
      REG_COEF_MID: coef_row[1] = val;
      REG_COEF_BOT: coef_row[2] = val;
      default: ;
    endcase
  endtask

  // Geometry writes carry random junk above the register width.
  task automatic set_geometry(int unsigned w, int unsigned h);
    logic [CFG_DATA_W-1:0] d;
    await_idle();
    d[47:32] = 16'($urandom());
    d[31:0]  = $urandom();
    d[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w);
    write_reg(REG_FRAME_WIDTH, d);
    d[31:0] = $urandom();
    d[HEIGHT_REG_W-1:0] = HEIGHT_REG_W'(h);
    write_reg(REG_FRAME_HEIGHT, d);
  endtask

  task automatic set_coefs(logic [CFG_DATA_W-1:0] top, logic [CFG_DATA_W-1:0] mid,
                           logic [CFG_DATA_W-1:0] bot);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2: return '0;
      3: return PIX_W'($urandom_range(511)) - 16'd256;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_row();
    logic [CFG_DATA_W-1:0] row;
    for (int m = 0; m < TAPS; m++) begin
      case ($urandom_range(9))
        0: row[COEF_W*m +: COEF_W] = COEF_MIN;
        1: row[COEF_W*m +: COEF_W] = COEF_MAX;
        2: row[COEF_W*m +: COEF_W] = Q12_MINUS_TWO;
        3: row[COEF_W*m +: COEF_W] = Q12_QUARTER;
        4: row[COEF_W*m +: COEF_W] = Q12_MINUS_QUARTER;
        5: row[COEF_W*m +: COEF_W] = Q12_ONE;
        6: row[COEF_W*m +: COEF_W] = '0;
        default: row[COEF_W*m +: COEF_W] = COEF_W'($urandom());
      endcase
    end
    return row;
  endfunction

  initial begin : stimulus
    int unsigned w_raw, h_raw, n, phase, random_start;
    bit hold;
    cfg_we         = 1'b0;
    cfg_index      = REG_FRAME_WIDTH;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    steady         = 1'b0;
    rst_n          = 1'b0;
    geo_w          = WIDTH_REG_W'(RESET_WIDTH);
    geo_h          = HEIGHT_REG_W'(RESET_HEIGHT);
    for (int l = 0; l < TAPS; l++) coef_row[l] = '0;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 3x2 frame, extreme taps, drain before any data and drain mid-frame.
    set_geometry(3, 2);
    set_coefs({COEF_MIN, COEF_MAX, COEF_MIN},
              {Q12_QUARTER, Q12_MINUS_TWO, COEF_MAX},
              {COEF_MIN, Q12_ONE, Q12_MINUS_QUARTER});
    queue_item(FUNC_DRAIN, PIX_MAX, 1'b0);
    queue_item(FUNC_PIXEL, PIX_MIN, 1'b0);
    queue_item(FUNC_PIXEL, PIX_MAX, 1'b0);
    queue_item(FUNC_PIXEL, '0, 1'b0);
    queue_item(FUNC_DRAIN, PIX_MIN, 1'b0);
    queue_item(FUNC_PIXEL, 16'hFFFF, 1'b0);
    queue_item(FUNC_PIXEL, PIX_MAX, 1'b0);
    queue_item(FUNC_PIXEL, PIX_MIN, 1'b0);
    repeat (5) queue_item(FUNC_DRAIN, rand_pixel(), 1'b0);

    // Undersized geometry clamps to 2x2; all-minimum taps on all-minimum pixels hit the
    // largest positive sum.
    set_geometry(0, 1);
    set_coefs({TAPS{COEF_MIN}}, {TAPS{COEF_MIN}}, {TAPS{COEF_MIN}});
    queue_item(FUNC_PIXEL, PIX_MIN, 1'b1);
    repeat (3) queue_item(FUNC_PIXEL, PIX_MIN, 1'b0);
    repeat (3) queue_item(FUNC_DRAIN, PIX_MAX, 1'b0);

    // Random phases: mostly whole frames plus flush drains, some ragged noise.
    random_start = items_pushed;
    phase = 0;
    while (items_pushed - random_start < RANDOM_ITEMS) begin
      await_idle();
      steady = (phase % 5 == 2);
      if (phase == 0 || $urandom_range(9) < 6) begin
        case ($urandom_range(9))
          0: w_raw = $urandom_range(1);
          1: w_raw = $urandom_range(16, 9);
          default: w_raw = $urandom_range(6, 2);
        endcase
        h_raw = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(5, 2);
        set_geometry(w_raw, h_raw);
      end
      // coefficient-only phases keep the stream going mid-frame
      if ($urandom_range(9) < 7) set_coefs(rand_row(), rand_row(), rand_row());
      hold = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(3, 1) * eff_width() * eff_height();
        for (int i = 0; i < n; i++) queue_item(FUNC_PIXEL, rand_pixel(), hold && i == 0);
        n = eff_width() + $urandom_range(3, 1);
        repeat (n) queue_item(FUNC_DRAIN, rand_pixel(), 1'b0);
      end else begin
        n = $urandom_range(20, 5);
        for (int i = 0; i < n; i++)
          queue_item(($urandom_range(3) == 0) ? FUNC_DRAIN : FUNC_PIXEL, rand_pixel(),
                     hold && i == 0);
      end
      phase++;
    end

    // Oversized width clamps to the line buffer size: a short start of a 2048x2 frame
    // releases nothing, then restart drops it.
    set_geometry(12'hFFF, 0);
    set_coefs(rand_row(), rand_row(), rand_row());
    repeat (40) queue_item(FUNC_PIXEL, rand_pixel(), 1'b0);
    repeat (3) queue_item(FUNC_DRAIN, rand_pixel(), 1'b0);

    // Tallest frame: a few rows only; the run ends before the rest of the frame is sent.
    set_geometry(2, 13'h1FFF);
    repeat (25) queue_item(FUNC_PIXEL, rand_pixel(), 1'b0);
    repeat (3) queue_item(FUNC_DRAIN, rand_pixel(), 1'b0);
    await_idle();

    $display("Run covered %0d input transfers, %0d checked results, %0d register writes,",
             items_taken, results_seen, cfg_writes);
    $display("random frames up to 16 wide, undersized geometry and widths clamped to %0d.",
             MAX_W);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/c3rb_pkg.sv
src/c3rb_stream_if.sv
src/c3rb_ram.sv
src/conv3x3_replicate_border_core.sv
tb/conv3x3_replicate_border_core_tb.sv
